// File: sv/mhfp_pkg.sv
// shared types and constants for the mqtt header field parser
`default_nettype none

package mhfp_pkg;

  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam logic [3:0] TYPE_ID_LO   = 4'd4;
  localparam logic [3:0] TYPE_ID_HI   = 4'd11;

  localparam logic [7:0] LEN_MORE     = 8'h80;
  localparam int         LEN_GROUP_W  = 7;
  localparam int         LEN_SUM_W    = 29;

  typedef enum logic [2:0] {
    REGION_FLAGS     = 3'd0,
    REGION_LENGTH    = 3'd1,
    REGION_TOPIC_LEN = 3'd2,
    REGION_TOPIC     = 3'd3,
    REGION_MSG_ID    = 3'd4,
    REGION_PAYLOAD   = 3'd5,
    REGION_OTHER     = 3'd6
  } region_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LENGTH   = 2'd1,
    ERR_HDR_LONG = 2'd2
  } err_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_BODY = 5'b00100,
    PH_ERR1 = 5'b01000,
    PH_ERR2 = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  region;
    logic [3:0]  packet_type;
    logic [1:0]  qos_level;
    logic [15:0] remaining_length;
    logic [15:0] topic_length;
    logic [15:0] pkt_id;
    logic [15:0] payload_length;
    logic        packet_last;
    logic [1:0]  error_code;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/mqtt_header_field_parser_core.sv
// MQTT received-packet header parser: one byte in, one tagged result out per
// transaction. Each byte is decoded in the same cycle it is accepted and its
// result is held in an output register, so the block takes one byte per clock
// while in_stall is low, each result showing in the next cycle; in_stall is
// raised only while a result sits in the output register and out_stall is high.
// The packet state registers update with every accepted byte and feed the decode.
`default_nettype none

module mqtt_header_field_parser_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  mhfp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output mhfp_pkg::out_item_t  out_data
);
  import mhfp_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  mhfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .item    (in_data),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: sv/mhfp_parse.sv
// parser state registers and per-byte decode logic
`default_nettype none

module mhfp_parse (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step_en,
  input  mhfp_pkg::in_item_t   item,
  output mhfp_pkg::out_item_t  result
);
  import mhfp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [1:0]  qos_r, qos_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] topic_r, topic_nxt;
  logic [15:0] id_r, id_nxt;

  logic [7:0]           b;
  logic [1:0]           k;
  logic [LEN_SUM_W-1:0] grp;
  logic [LEN_SUM_W-1:0] sum;
  logic [15:0]          c;
  logic [16:0]          tend;
  logic [17:0]          tend_id;
  logic [15:0]          left_dec;
  logic [17:0]          hdr_chk;
  logic                 carries;
  logic                 bad;
  region_t              region;
  err_t                 err;
  logic                 last;
  logic [16:0]          diff;
  logic [17:0]          hdr;
  logic [15:0]          payload;

  assign b       = item.rx_byte;
  assign k       = cnt_r[1:0];
  assign carries = (kind_r >= TYPE_ID_LO) && (kind_r <= TYPE_ID_HI);
  assign c       = acc_r - left_r;
  assign tend    = 17'd2 + {1'b0, topic_r};
  assign tend_id = {1'b0, tend} + 18'd2;
  assign left_dec = left_r - 16'd1;

  always_comb begin
    grp = {{(LEN_SUM_W-LEN_GROUP_W){1'b0}}, b[LEN_GROUP_W-1:0]};
    case (k)
      2'd0: grp = grp;
      2'd1: grp = grp << LEN_GROUP_W;
      2'd2: grp = grp << (2 * LEN_GROUP_W);
      default: grp = grp << (3 * LEN_GROUP_W);
    endcase
  end

  assign sum = {{(LEN_SUM_W-16){1'b0}}, acc_r} + grp;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    qos_nxt   = qos_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    topic_nxt = topic_r;
    id_nxt    = id_r;
    region    = REGION_OTHER;
    err       = ERR_NONE;
    last      = 1'b0;
    bad       = 1'b0;
    hdr_chk   = '0;
    if (item.first_of_packet) begin
      kind_nxt  = b[7:4];
      qos_nxt   = b[2:1];
      acc_nxt   = '0;
      cnt_nxt   = '0;
      left_nxt  = '0;
      topic_nxt = '0;
      id_nxt    = '0;
      phase_nxt = PH_LEN;
      region    = REGION_FLAGS;
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          region = REGION_LENGTH;
          if (sum[LEN_SUM_W-1:16] != '0) begin
            phase_nxt = PH_ERR1;
            err       = ERR_LENGTH;
          end else begin
            acc_nxt = sum[15:0];
            cnt_nxt = {1'b0, k} + 3'd1;
            if ((b & LEN_MORE) != 8'h00) begin
              if (k == 2'd3) begin
                phase_nxt = PH_ERR1;
                err       = ERR_LENGTH;
              end
            end else begin
              left_nxt = sum[15:0];
              if ((kind_r == TYPE_PUBLISH || carries) && sum[15:0] < 16'd2) begin
                phase_nxt = PH_ERR2;
                err       = ERR_HDR_LONG;
              end else if (sum[15:0] == 16'd0) begin
                last      = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          if (kind_r == TYPE_PUBLISH) begin
            if (c == 16'd0) begin
              region    = REGION_TOPIC_LEN;
              topic_nxt = {b, 8'h00};
            end else if (c == 16'd1) begin
              region    = REGION_TOPIC_LEN;
              topic_nxt = topic_r | {8'h00, b};
              hdr_chk   = 18'd2 + {2'b00, topic_nxt} + ((qos_r != 2'd0) ? 18'd2 : 18'd0);
              bad       = hdr_chk > {2'b00, acc_r};
            end else if ({1'b0, c} < tend) begin
              region = REGION_TOPIC;
            end else if (qos_r != 2'd0 && {2'b00, c} < tend_id) begin
              region = REGION_MSG_ID;
              if ({1'b0, c} == tend) id_nxt = {b, 8'h00};
              else                   id_nxt = id_r | {8'h00, b};
            end else begin
              region = REGION_PAYLOAD;
            end
          end else if (carries && c < 16'd2) begin
            region = REGION_MSG_ID;
            if (c == 16'd0) id_nxt = {b, 8'h00};
            else            id_nxt = id_r | {8'h00, b};
          end
          if (bad) begin
            phase_nxt = PH_ERR2;
            err       = ERR_HDR_LONG;
          end else begin
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              last      = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_ERR1: err = ERR_LENGTH;
        PH_ERR2: err = ERR_HDR_LONG;
        default: ;
      endcase
    end
  end

  // payload length from the updated state
  assign diff = {1'b0, acc_nxt} - {1'b0, left_nxt};
  assign hdr  = 18'd2 + {2'b00, topic_nxt} + ((qos_nxt != 2'd0) ? 18'd2 : 18'd0);

  always_comb begin
    payload = '0;
    if (kind_nxt == TYPE_PUBLISH && (phase_nxt == PH_BODY || phase_nxt == PH_IDLE) &&
        (diff[16] || diff[15:0] >= 16'd2) && {2'b00, acc_nxt} >= hdr) begin
      payload = acc_nxt - hdr[15:0];
    end
  end

  always_comb begin
    result.data_byte        = b;
    result.region           = region;
    result.packet_type      = kind_nxt;
    result.qos_level        = qos_nxt;
    result.remaining_length = acc_nxt;
    result.topic_length     = topic_nxt;
    result.pkt_id           = id_nxt;
    result.payload_length   = payload;
    result.packet_last      = last;
    result.error_code       = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= '0;
      qos_r   <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
      topic_r <= '0;
      id_r    <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      qos_r   <= qos_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
      topic_r <= topic_nxt;
      id_r    <= id_nxt;
    end
  end

endmodule

`default_nettype wire

// File: tb/mqtt_header_field_parser_core_test.sv
// testbench for mqtt_header_field_parser_core: mqtt byte streams checked against a header tracker
`timescale 1ns / 100ps

module mqtt_header_field_parser_core_test;
  import mhfp_pkg::*;

  class mqtt_tag_board;
    phase_t      phase;
    logic [3:0]  kind;
    logic [1:0]  qos;
    logic [15:0] len_sum;
    logic [2:0]  len_bytes;
    logic [15:0] left;
    logic [15:0] topic_size;
    logic [15:0] msg_id;
    out_item_t   tags_due[$];
    int          mismatches;

    function new();
      phase = PH_IDLE;
      kind = '0;
      qos = '0;
      len_sum = '0;
      len_bytes = '0;
      left = '0;
      topic_size = '0;
      msg_id = '0;
      mismatches = 0;
    endfunction

    function bit carries_msg_id();
      return kind >= TYPE_ID_LO && kind <= TYPE_ID_HI;
    endfunction

    function logic [31:0] header_bytes();
      return 32'd2 + {16'd0, topic_size} + ((qos != 2'd0) ? 32'd2 : 32'd0);
    endfunction

    // work out the tagged result of one accepted byte
    function void take_byte(in_item_t item);
      logic [7:0]  b;
      logic [1:0]  k;
      logic [31:0] sum;
      logic [31:0] pos;
      logic [31:0] tend;
      logic [31:0] hdr;
      logic [15:0] pay;
      region_t     tag;
      err_t        err;
      logic        last;
      logic        bad;
      out_item_t   r;
      b = item.rx_byte;
      tag = REGION_OTHER;
      err = ERR_NONE;
      last = 1'b0;
      pay = '0;
      bad = 1'b0;
      if (item.first_of_packet) begin
        kind = b[7:4];
        qos = b[2:1];
        len_sum = '0;
        len_bytes = '0;
        left = '0;
        topic_size = '0;
        msg_id = '0;
        phase = PH_LEN;
        tag = REGION_FLAGS;
      end else if (phase == PH_LEN) begin
        k = len_bytes[1:0];
        sum = {16'd0, len_sum} + ({25'd0, b[6:0]} << (7 * int'(k)));
        tag = REGION_LENGTH;
        if (sum > 32'd65535) begin
          phase = PH_ERR1;
          err = ERR_LENGTH;
        end else begin
          len_sum = sum[15:0];
          len_bytes = {1'b0, k} + 3'd1;
          if (b[7]) begin
            if (k == 2'd3) begin
              phase = PH_ERR1;
              err = ERR_LENGTH;
            end
          end else begin
            left = len_sum;
            if ((kind == TYPE_PUBLISH || carries_msg_id()) && len_sum < 16'd2) begin
              phase = PH_ERR2;
              err = ERR_HDR_LONG;
            end else if (len_sum == 16'd0) begin
              last = 1'b1;
              phase = PH_IDLE;
            end else begin
              phase = PH_BODY;
            end
          end
        end
      end else if (phase == PH_BODY) begin
        pos = {16'd0, len_sum} - {16'd0, left};
        tend = 32'd2 + {16'd0, topic_size};
        if (kind == TYPE_PUBLISH) begin
          if (pos == 32'd0) begin
            tag = REGION_TOPIC_LEN;
            topic_size = {b, 8'd0};
          end else if (pos == 32'd1) begin
            tag = REGION_TOPIC_LEN;
            topic_size = topic_size | {8'd0, b};
            if (header_bytes() > {16'd0, len_sum}) bad = 1'b1;
          end else if (pos < tend) begin
            tag = REGION_TOPIC;
          end else if (qos != 2'd0 && pos < tend + 32'd2) begin
            tag = REGION_MSG_ID;
            if (pos == tend) msg_id = {b, 8'd0};
            else msg_id = msg_id | {8'd0, b};
          end else begin
            tag = REGION_PAYLOAD;
          end
        end else if (carries_msg_id() && pos < 32'd2) begin
          tag = REGION_MSG_ID;
          if (pos == 32'd0) msg_id = {b, 8'd0};
          else msg_id = msg_id | {8'd0, b};
        end
        if (bad) begin
          phase = PH_ERR2;
          err = ERR_HDR_LONG;
        end else begin
          left = left - 16'd1;
          if (left == 16'd0) begin
            last = 1'b1;
            phase = PH_IDLE;
          end
        end
      end else if (phase == PH_ERR1) begin
        err = ERR_LENGTH;
      end else if (phase == PH_ERR2) begin
        err = ERR_HDR_LONG;
      end
      if (kind == TYPE_PUBLISH && (phase == PH_BODY || phase == PH_IDLE) &&
          ({16'd0, len_sum} - {16'd0, left}) >= 32'd2) begin
        hdr = header_bytes();
        if ({16'd0, len_sum} >= hdr) pay = len_sum - hdr[15:0];
      end
      r.data_byte = b;
      r.region = tag;
      r.packet_type = kind;
      r.qos_level = qos;
      r.remaining_length = len_sum;
      r.topic_length = topic_size;
      r.pkt_id = msg_id;
      r.payload_length = pay;
      r.packet_last = last;
      r.error_code = err;
      tags_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        if (mismatches < 200) $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_tagged(out_item_t got);
      out_item_t w;
      if (tags_due.size() == 0) begin
        $error("result with no transaction pending: %p", got);
        mismatches++;
        return;
      end
      w = tags_due.pop_front();
      compare_field("data_byte", 16'(w.data_byte), 16'(got.data_byte));
      compare_field("region", 16'(w.region), 16'(got.region));
      compare_field("packet_type", 16'(w.packet_type), 16'(got.packet_type));
      compare_field("qos_level", 16'(w.qos_level), 16'(got.qos_level));
      compare_field("remaining_length", w.remaining_length, got.remaining_length);
      compare_field("topic_length", w.topic_length, got.topic_length);
      compare_field("pkt_id", w.pkt_id, got.pkt_id);
      compare_field("payload_length", w.payload_length, got.payload_length);
      compare_field("packet_last", 16'(w.packet_last), 16'(got.packet_last));
      compare_field("error_code", 16'(w.error_code), 16'(got.error_code));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  mqtt_tag_board board = new();
  logic [7:0]    frame[$];
  bit            quiet = 1'b0;
  int            sent = 0;

  mqtt_header_field_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_tagged(out_data);
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // remaining length, low group first
  function automatic void put_len(int unsigned n);
    logic [7:0] d;
    do begin
      d = {1'b0, n[6:0]};
      n = n >> 7;
      if (n != 0) d[7] = 1'b1;
      frame.push_back(d);
    end while (n != 0);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first);
    in_item_t item;
    item.rx_byte = b;
    item.first_of_packet = first;
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    board.take_byte(item);
    sent++;
  endtask

  task automatic ship_frame(input int cut);
    for (int i = 0; i < cut; i++) send_byte(frame[i], i == 0);
    frame.delete();
  endtask

  task automatic random_packet();
    int          pick;
    int          t;
    int          body;
    int          v;
    int          cut;
    logic [7:0]  flags;
    logic [15:0] tl;
    pick = $urandom_range(99);
    flags = rand_byte();
    frame.delete();
    if (pick < 40) begin
      flags[7:4] = TYPE_PUBLISH;
      t = $urandom_range(6);
      body = t + ((flags[2:1] != 2'd0) ? 2 : 0) + $urandom_range(10);
      frame.push_back(flags);
      put_len(2 + body);
      frame.push_back(8'd0);
      frame.push_back(t[7:0]);
      repeat (body) frame.push_back(rand_byte());
    end else if (pick < 70) begin
      v = $urandom_range(TYPE_ID_HI, TYPE_ID_LO);
      flags[7:4] = v[3:0];
      body = 2 + $urandom_range(4);
      frame.push_back(flags);
      put_len(body);
      repeat (body) frame.push_back(rand_byte());
    end else if (pick < 82) begin
      v = $urandom_range(12, 18);
      flags[7:4] = v[3:0];
      body = $urandom_range(5);
      frame.push_back(flags);
      put_len(body);
      repeat (body) frame.push_back(rand_byte());
    end else if (pick < 89) begin
      if ($urandom_range(1)) flags[7:4] = TYPE_PUBLISH;
      frame.push_back(flags);
      case ($urandom_range(5))
        0: put_len(65535);
        1: put_len(16384);
        2: put_len($urandom_range(65535));
        3: put_len($urandom_range(2097151, 65536));
        4: put_len($urandom_range(32'h0FFF_FFFF, 32'h0020_0000));
        default: repeat (4) frame.push_back(rand_byte() | 8'h80);
      endcase
      tl = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(65535));
      frame.push_back(tl[15:8]);
      frame.push_back(tl[7:0]);
      repeat ($urandom_range(4)) frame.push_back(rand_byte());
    end else if (pick < 95) begin
      if ($urandom_range(2) == 0) begin
        v = $urandom_range(TYPE_ID_HI, TYPE_ID_LO);
        flags[7:4] = v[3:0];
        body = $urandom_range(1);
      end else begin
        flags[7:4] = TYPE_PUBLISH;
        body = $urandom_range(5);
      end
      frame.push_back(flags);
      put_len(body);
      frame.push_back(($urandom_range(7) == 0) ? rand_byte() : 8'd0);
      frame.push_back(8'($urandom_range(body + 8, body)));
      repeat ($urandom_range(3)) frame.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(rand_byte(), $urandom_range(9) == 0);
      return;
    end
    cut = frame.size();
    if (pick < 82 && $urandom_range(15) == 0) cut = $urandom_range(frame.size() - 1, 1);
    ship_frame(cut);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // byte outside any packet
    send_byte(8'hFF, 1'b0);
    // publish, qos 3, one topic byte, id only
    send_byte(8'h36, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // zero length
    send_byte(8'hC0, 1'b1);
    send_byte(8'h00, 1'b0);
    // start mark mid-packet
    send_byte(8'h82, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'hAB, 1'b0);
    // publish with length below two, then a byte after the error
    send_byte(8'h30, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h55, 1'b0);
    // length sum overflow
    send_byte(8'h20, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    // fourth length byte still marked more
    send_byte(8'h10, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    while (sent < 1450) begin
      quiet = (sent >= 600 && sent < 850);
      random_packet();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    while (board.tags_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.tags_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/mhfp_pkg.sv
sv/mhfp_parse.sv
sv/mqtt_header_field_parser_core.sv
tb/mqtt_header_field_parser_core_test.sv
